FILE: hdl/queue_with_middle_insert_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH
`define QUEUE_WITH_MIDDLE_INSERT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define QWMI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define QWMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/qwmi_pkg.sv
// Package with sizes, codes and the cell control type of the queue.
package qwmi_pkg;

    localparam int DEPTH = 256;
    localparam int DATA_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef struct packed {
        logic              shift_fwd;
        logic              insert;
        logic [IDX_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } cell_ctrl_t;

endpackage

FILE: hdl/qwmi_cell.sv
// One storage cell of the queue chain: holds, takes a neighbor's value, or loads new data.
module qwmi_cell
    import qwmi_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  cell_index,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] from_prev,
    input  logic [DATA_W-1:0] from_next,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // On a pop every cell takes its back neighbor; on a store the cells behind
    // the insert position take their front neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_fwd)
        begin
            data_next = from_next;
        end
        else if (ctrl.insert)
        begin
            if (cell_index == ctrl.pos)
            begin
                data_next = ctrl.data;
            end
            else if (cell_index > ctrl.pos)
            begin
                data_next = from_prev;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hdl/queue_with_middle_insert.sv
// Top level of the bounded queue with push, pop and middle insert.
// A result is registered and appears in the cycle after its transaction is accepted.
// One command per cycle while not stalled; the whole cell chain updates together.
// The command side stalls only while a finished result waits to be taken.
// Reset empties the queue at once; cell contents are left as they are.
module queue_with_middle_insert
    import qwmi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  logic [1:0]        command,
    input  logic signed [31:0] value,
    output logic              result_valid,
    input  logic              result_stall,
    output logic signed [31:0] popped_value,
    output logic [1:0]        status
);

`include "queue_with_middle_insert_defines.svh"

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    logic [DATA_W-1:0] result_popped_reg;
    logic [DATA_W-1:0] result_popped_next;
    logic [1:0]        result_status_reg;
    logic [1:0]        result_status_next;

    logic              accept;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W:0]    mid_sum;
    cell_ctrl_t        ctrl;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] prev_data [DEPTH];
    logic [DATA_W-1:0] next_data [DEPTH];

    assign cmd_stall = result_valid_reg && result_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign mid_sum   = {1'b0, count_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        ctrl.shift_fwd = accept && (command == CMD_POP) && !is_empty;
        ctrl.insert    = accept && ((command == CMD_PUSH) || (command == CMD_INSERT))
                         && !is_full;
        ctrl.data      = value;
        // When not full the count is below DEPTH, so both positions fit the index.
        if (command == CMD_INSERT)
        begin
            ctrl.pos = mid_sum[IDX_W:1];
        end
        else
        begin
            ctrl.pos = count_reg[IDX_W-1:0];
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        // The chain ends feed back their own value; only the last one is taken, on a pop.
        assign prev_data[g] = cell_data[(g == 0) ? 0 : g - 1];
        assign next_data[g] = cell_data[(g == DEPTH - 1) ? g : g + 1];

        qwmi_cell u_cell
        (
            .clk        (clk),
            .cell_index (IDX_W'(g)),
            .ctrl       (ctrl),
            .from_prev  (prev_data[g]),
            .from_next  (next_data[g]),
            .data       (cell_data[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.shift_fwd)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        result_popped_next = '0;
        result_status_next = ST_STORED;
        case (command)
            CMD_PUSH, CMD_INSERT:
            begin
                result_status_next = is_full ? ST_FULL : ST_STORED;
            end
            CMD_POP:
            begin
                if (is_empty)
                begin
                    result_status_next = ST_EMPTY;
                end
                else
                begin
                    result_status_next = ST_POPPED;
                    result_popped_next = cell_data[0];
                end
            end
            default:
            begin
                result_status_next = ST_STORED;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else
        begin
            result_valid_next = result_valid_reg && result_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_popped_reg <= result_popped_next;
            result_status_reg <= result_status_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign popped_value = result_popped_reg;
    assign status       = result_status_reg;

    `QWMI_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "fill count above depth")

    `QWMI_ASSERT_NEXT(a_pop_front,
        accept && (command == CMD_POP) && !is_empty,
        (count_reg == $past(count_reg) - CNT_W'(1)) && (result_status_reg == ST_POPPED)
            && (result_popped_reg == $past(cell_data[0])),
        "pop did not remove the front entry")

    `QWMI_ASSERT_NEXT(a_full_drop,
        accept && ((command == CMD_PUSH) || (command == CMD_INSERT)) && is_full,
        (count_reg == $past(count_reg)) && (result_status_reg == ST_FULL),
        "store on a full queue was not dropped")

    `QWMI_ASSERT_NEXT(a_store_slot,
        ctrl.insert,
        cell_data[$past(ctrl.pos)] == $past(value),
        "stored value not found at its position")

endmodule

FILE: tb/queue_with_middle_insert_test.sv
// Self-checking testbench for the bounded queue with push, pop and middle insert.
module queue_with_middle_insert_test
    import qwmi_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] val;
    } queue_cmd_t;

    typedef struct {
        logic signed [31:0] popped;
        status_t            status;
    } queue_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    logic [1:0]        command = CMD_PUSH;
    logic signed [31:0] value = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic signed [31:0] popped_value;
    logic [1:0]        status;

    queue_cmd_t         pending_cmds[$];
    queue_result_t      awaited_results[$];
    logic signed [31:0] model_entries[$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    logic hold_arm = 1'b0;
    int hold_left = 0;
    int error_count = 0;
    int cycle_count = 0;
    int gen_fill = 0;

    queue_with_middle_insert DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .popped_value (popped_value),
        .status       (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one command to the queue model and returns the result it should give.
    function automatic queue_result_t predict_queue(logic [1:0] cmd, logic signed [31:0] val);
        queue_result_t res;
        int pos;
        res.popped = '0;
        res.status = ST_STORED;
        if (cmd == CMD_PUSH || cmd == CMD_INSERT)
        begin
            if (model_entries.size() >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                pos = (cmd == CMD_PUSH) ? model_entries.size() : (model_entries.size() + 1) / 2;
                if (pos >= model_entries.size())
                    model_entries.push_back(val);
                else
                    model_entries.insert(pos, val);
            end
        end
        else if (cmd == CMD_POP)
        begin
            if (model_entries.size() == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.popped = model_entries.pop_front();
                res.status = ST_POPPED;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Queues a command for the driver and tracks the fill level that it leads to.
    task automatic add_cmd(logic [1:0] cmd, logic signed [31:0] val);
        queue_cmd_t item;
        item.cmd = cmd;
        item.val = val;
        pending_cmds.push_back(item);
        if ((cmd == CMD_PUSH || cmd == CMD_INSERT) && gen_fill < DEPTH)
            gen_fill++;
        else if (cmd == CMD_POP && gen_fill > 0)
            gen_fill--;
    endtask

    // Draws one random command: 3% unused code, else store_pct is the percent share of push and insert.
    task automatic add_random_cmd(int store_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            add_cmd(CMD_UNUSED, $urandom);
        else if ($urandom_range(99) < store_pct)
            add_cmd($urandom_range(1) ? CMD_INSERT : CMD_PUSH, $urandom);
        else
            add_cmd(CMD_POP, $urandom);
    endtask

    task automatic wait_all_done();
        @(negedge clk);
        while (pending_cmds.size() != 0 || awaited_results.size() != 0 || cmd_valid)
            @(negedge clk);
    endtask

    // Driver: records each accepted transaction and offers the next pending one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                awaited_results.push_back(predict_queue(command, value));
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    command <= pending_cmds[0].cmd;
                    value <= pending_cmds[0].val;
                    void'(pending_cmds.pop_front());
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result popped_value=%0d status=%0d",
                                              popped_value, status));
                end
                else
                begin
                    if (popped_value !== awaited_results[0].popped)
                        report_mismatch($sformatf("popped_value got %0d want %0d",
                                                  popped_value, awaited_results[0].popped));
                    if (status !== awaited_results[0].status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  status, awaited_results[0].status));
                    void'(awaited_results.pop_front());
                end
            end
            result_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so that it runs beside the driver.
    always @(posedge clk)
    begin
        if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("queue_with_middle_insert_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty-queue cases, extremes, insert positions at odd and even fill, then random commands.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        add_cmd(CMD_POP, 32'sh7fffffff);
        add_cmd(CMD_UNUSED, -32'sd1);
        add_cmd(CMD_INSERT, 32'sh80000000);
        add_cmd(CMD_PUSH, 32'sh7fffffff);
        add_cmd(CMD_INSERT, 32'sd0);
        add_cmd(CMD_INSERT, -32'sd1);
        add_cmd(CMD_PUSH, 32'sd1);
        add_cmd(CMD_INSERT, 32'sh55555555);
        add_cmd(CMD_UNUSED, 32'shaaaaaaaa);
        add_cmd(CMD_POP, 32'shaaaaaaaa);
        add_cmd(CMD_POP, 32'sh55555555);
        add_cmd(CMD_POP, -32'sd1);
        add_cmd(CMD_POP, 32'sd0);
        add_cmd(CMD_POP, 32'sh80000000);
        add_cmd(CMD_POP, 32'sh7fffffff);
        add_cmd(CMD_POP, -32'sd1);
        add_cmd(CMD_INSERT, 32'sh12345678);
        add_cmd(CMD_POP, 32'sd0);
        repeat (40) add_random_cmd(55);
        wait_all_done();

        sender_idle_pct = 63;
        receiver_stall_pct = 0;
        repeat (40) add_random_cmd(60);
        wait_all_done();

        // Fill to the top under a long hold-off, then hammer the full queue.
        sender_idle_pct = 0;
        receiver_stall_pct = 63;
        while (gen_fill < DEPTH)
            add_random_cmd(100);
        add_cmd(CMD_PUSH, $urandom);
        add_cmd(CMD_INSERT, $urandom);
        add_cmd(CMD_POP, $urandom);
        add_cmd(CMD_INSERT, $urandom);
        add_cmd(CMD_INSERT, $urandom);
        add_cmd(CMD_PUSH, $urandom);
        add_cmd(CMD_UNUSED, $urandom);
        @(posedge clk);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
        wait_all_done();

        // Drain to empty and past it, then run random commands.
        sender_idle_pct = 38;
        receiver_stall_pct = 38;
        while (gen_fill > 0)
            add_random_cmd(0);
        repeat (4) add_cmd(CMD_POP, $urandom);
        repeat (30) add_random_cmd(55);
        wait_all_done();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("queue_with_middle_insert_test: done, clean");
        else
            $display("queue_with_middle_insert_test: done, errors");
        $finish;
    end

endmodule
